>>> sv/date_difference_in_days_top_defines.svh
// Assertion macros for the date difference block.
// Used at the end of date_difference_in_days_top; depends on nothing else.
`ifndef DATE_DIFFERENCE_IN_DAYS_TOP_DEFINES_SVH
`define DATE_DIFFERENCE_IN_DAYS_TOP_DEFINES_SVH

// same-cycle implication
`define DDD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ddd: same-cycle check failed");

// next-cycle implication
`define DDD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ddd: next-cycle check failed");

`endif

>>> sv/ddd_pkg.sv
// Shared types, constants and calendar tables for the date difference block.
// No dependencies.
`default_nettype none

package ddd_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int YY_W    = 15;  // year offset by 400
  localparam int Q100_W  = 8;   // quotient by 100
  localparam int DNUM_W  = 23;  // day number
  localparam int PART_W  = 13;  // small terms of the day number
  localparam int COUNT_W = 22;

  localparam logic [YY_W-1:0]    YEAR_OFFSET = 15'd400;
  localparam logic [12:0]        DIV100_MUL  = 13'd5243;  // 2^19 / 100, rounded up
  localparam int                 DIV100_SHIFT = 19;
  localparam logic [8:0]         DAYS_PER_YEAR = 9'd365;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 22'd4194303;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } adv_t;

  // length of a month, 0 for a bad month
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // days before a month in a March-based year, index 0 is March
  function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] mi);
    logic [8:0] off;
    unique case (mi)
      4'd0:    off = 9'd0;
      4'd1:    off = 9'd31;
      4'd2:    off = 9'd61;
      4'd3:    off = 9'd92;
      4'd4:    off = 9'd122;
      4'd5:    off = 9'd153;
      4'd6:    off = 9'd184;
      4'd7:    off = 9'd214;
      4'd8:    off = 9'd245;
      4'd9:    off = 9'd275;
      4'd10:   off = 9'd306;
      4'd11:   off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

>>> sv/ddd_date_lane.sv
// Three-stage lane: checks one date and turns it into a day number.
// Depends on ddd_pkg; stage enables come from the top level.
`default_nettype none

module ddd_date_lane (
  input  wire                           clk,
  input  wire ddd_pkg::adv_t            adv,
  input  wire [ddd_pkg::DAY_W-1:0]      day,
  input  wire [ddd_pkg::MONTH_W-1:0]    month,
  input  wire [ddd_pkg::YEAR_W-1:0]     year,
  output logic [ddd_pkg::DNUM_W-1:0]    day_num,
  output logic                          ok
);

  // stage 1
  logic [ddd_pkg::DAY_W-1:0]   d1;
  logic [ddd_pkg::MONTH_W-1:0] m1;
  logic [ddd_pkg::MONTH_W-1:0] mi1;
  logic [ddd_pkg::YEAR_W-1:0]  y1;
  logic [ddd_pkg::YY_W-1:0]    yy1;
  logic [ddd_pkg::Q100_W-1:0]  qy1;
  logic [ddd_pkg::Q100_W-1:0]  qyy1;

  logic                        early;
  logic [ddd_pkg::YY_W-1:0]    yy_next;
  logic [ddd_pkg::MONTH_W-1:0] mi_next;
  logic [27:0]                 prod_y;
  logic [27:0]                 prod_yy;

  always_comb begin
    early   = (month <= 4'd2);
    yy_next = ddd_pkg::YY_W'(year) + ddd_pkg::YEAR_OFFSET - ddd_pkg::YY_W'(early);
    mi_next = early ? 4'(month + 4'd9) : 4'(month - 4'd3);
    prod_y  = 28'(year) * 28'(ddd_pkg::DIV100_MUL);
    prod_yy = 28'(yy_next) * 28'(ddd_pkg::DIV100_MUL);
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      d1   <= day;
      m1   <= month;
      mi1  <= mi_next;
      y1   <= year;
      yy1  <= yy_next;
      qy1  <= prod_y[ddd_pkg::DIV100_SHIFT +: ddd_pkg::Q100_W];
      qyy1 <= prod_yy[ddd_pkg::DIV100_SHIFT +: ddd_pkg::Q100_W];
    end
  end

  // stage 2
  logic                        ok2;
  logic [ddd_pkg::DNUM_W-1:0]  a2;
  logic [ddd_pkg::PART_W-1:0]  b2;

  logic                        cent;
  logic                        leap;
  logic [ddd_pkg::DAY_W-1:0]   len;
  logic [13:0]                 b_sum;

  always_comb begin
    cent  = (y1 == 14'(qy1 * 14'd100));
    leap  = (y1[1:0] == 2'd0 && !cent) || (cent && qy1[1:0] == 2'd0);
    len   = ddd_pkg::month_len(m1, leap);
    b_sum = 14'(yy1[ddd_pkg::YY_W-1:2]) - 14'(qyy1) + 14'(qyy1[ddd_pkg::Q100_W-1:2])
          + 14'(ddd_pkg::month_offset(mi1)) + 14'(d1);
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      ok2 <= (len != 5'd0) && (d1 != 5'd0) && (d1 <= len);
      a2  <= ddd_pkg::DNUM_W'(yy1) * ddd_pkg::DNUM_W'(ddd_pkg::DAYS_PER_YEAR);
      b2  <= b_sum[ddd_pkg::PART_W-1:0];
    end
  end

  // stage 3
  always_ff @(posedge clk) begin
    if (adv.s3) begin
      ok      <= ok2;
      day_num <= a2 + ddd_pkg::DNUM_W'(b2);
    end
  end

endmodule

`default_nettype wire

>>> sv/date_difference_in_days_top.sv
// Top level of the date difference block: two date lanes, pipeline control
// and the output stage. Depends on ddd_pkg, ddd_date_lane and the defines header.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+---------------------------------------------
//  in      | in_valid  | in_stall  | start_*/end_* day, month, year, count_end_day
//  out     | out_valid | out_stall | day_count, date_invalid
//
// Four register stages; an accepted item moves through v1, v2 and v3 to out_valid.
// One item per cycle sustained while out_stall is low; each stage advances
// when it is empty or the stage after it advances, so a stall backs up
// without loss. Reset clears the valid bits only; no clearing pass.
`default_nettype none
`include "date_difference_in_days_top_defines.svh"

module date_difference_in_days_top (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire [ddd_pkg::DAY_W-1:0]        start_day,
  input  wire [ddd_pkg::MONTH_W-1:0]      start_month,
  input  wire [ddd_pkg::YEAR_W-1:0]       start_year,
  input  wire [ddd_pkg::DAY_W-1:0]        end_day,
  input  wire [ddd_pkg::MONTH_W-1:0]      end_month,
  input  wire [ddd_pkg::YEAR_W-1:0]       end_year,
  input  wire                             count_end_day,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic [ddd_pkg::COUNT_W-1:0]     day_count,
  output logic                            date_invalid
);

  logic v1, v2, v3;
  logic inc1, inc2, inc3;
  logic adv4;
  ddd_pkg::adv_t adv;

  always_comb begin
    adv4     = !out_valid || !out_stall;
    adv.s3   = !v3 || adv4;
    adv.s2   = !v2 || adv.s3;
    adv.s1   = !v1 || adv.s2;
    in_stall = !adv.s1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv.s1) v1 <= in_valid;
      if (adv.s2) v2 <= v1;
      if (adv.s3) v3 <= v2;
      if (adv4)   out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) inc1 <= count_end_day;
    if (adv.s2) inc2 <= inc1;
    if (adv.s3) inc3 <= inc2;
  end

  logic [ddd_pkg::DNUM_W-1:0] ns;
  logic [ddd_pkg::DNUM_W-1:0] ne;
  logic                       ok_s;
  logic                       ok_e;

  ddd_date_lane u_start (
    .clk     (clk),
    .adv     (adv),
    .day     (start_day),
    .month   (start_month),
    .year    (start_year),
    .day_num (ns),
    .ok      (ok_s)
  );

  ddd_date_lane u_end (
    .clk     (clk),
    .adv     (adv),
    .day     (end_day),
    .month   (end_month),
    .year    (end_year),
    .day_num (ne),
    .ok      (ok_e)
  );

  // stage 4: difference, end-day flag, saturation, zero for an invalid date
  logic [ddd_pkg::DNUM_W-1:0]  diff;
  logic [ddd_pkg::DNUM_W:0]    total;
  logic [ddd_pkg::COUNT_W-1:0] count_next;
  logic                        bad;

  always_comb begin
    bad   = !(ok_s && ok_e);
    diff  = (ne > ns) ? ne - ns : '0;
    total = (ddd_pkg::DNUM_W + 1)'(diff) + (ddd_pkg::DNUM_W + 1)'(inc3);
    if (bad) begin
      count_next = '0;
    end else if (total > (ddd_pkg::DNUM_W + 1)'(ddd_pkg::COUNT_MAX)) begin
      count_next = ddd_pkg::COUNT_MAX;
    end else begin
      count_next = total[ddd_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      day_count    <= count_next;
      date_invalid <= bad;
    end
  end

  `DDD_ASSERT_IMP(a_invalid_zero, clk, rst, out_valid && date_invalid, day_count == '0)
  `DDD_ASSERT_IMP(a_stall_full, clk, rst, in_stall, v1 && v2 && v3 && out_valid && out_stall)
  `DDD_ASSERT_NXT(a_no_repeat, clk, rst, out_valid && !out_stall && !v3, !out_valid)

endmodule

`default_nettype wire
